/* rtl/abd_pkg.sv */
// shared constants, coefficient tables and types for the adpcm block decoder
package abd_pkg;

   localparam logic [15:0] MAX_SAMPLES = 16'hffff;

   localparam logic [3:0] POS_HEADER = 4'd0;
   localparam logic [3:0] POS_FLAGS  = 4'd1;
   localparam logic [3:0] POS_WRAP   = 4'd0;

   localparam logic [7:0] FLAG_END      = 8'd3;
   localparam logic [7:0] FLAG_LOOP     = 8'd6;
   localparam logic [7:0] FLAG_END_LOOP = 8'd7;

   typedef logic signed [15:0] pcm_type;
   typedef logic signed [7:0]  coef_type;

   function automatic coef_type coef_first(input logic [3:0] filter);
      coef_type c;
      case (filter)
         4'd1:    c = 8'sd60;
         4'd2:    c = 8'sd115;
         4'd3:    c = 8'sd98;
         4'd4:    c = 8'sd122;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

   function automatic coef_type coef_second(input logic [3:0] filter);
      coef_type c;
      case (filter)
         4'd2:    c = -8'sd52;
         4'd3:    c = -8'sd55;
         4'd4:    c = -8'sd60;
         default: c = 8'sd0;
      endcase
      return c;
   endfunction

endpackage

/* rtl/abd_req_if.sv */
// request channel: one stream byte per beat
interface abd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       voice_start;

   modport source (output valid, data_byte, voice_start, input ready);
   modport sink (input valid, data_byte, voice_start, output ready);
endinterface

/* rtl/abd_rsp_if.sv */
// response channel: one decoded sample per beat
interface abd_rsp_if;
   logic                 valid;
   logic                 ready;
   abd_pkg::pcm_type     sample;
   logic                 pair_last;
   logic                 loop_point_next;
   logic                 voice_end;
   logic                 overflow;

   modport source (output valid, sample, pair_last, loop_point_next, voice_end, overflow,
                   input ready);
   modport sink (input valid, sample, pair_last, loop_point_next, voice_end, overflow,
                 output ready);
endinterface

/* rtl/adpcm_block_decoder.sv */
// adpcm block decoder: streams 16-byte blocks in, 16-bit pcm samples out
//
// req_chan carries one stream byte per beat with voice_start, which clears
// the voice before that byte. rsp_chan carries one sample per beat with its
// pair, loop, end and overflow marks.
// an accepted byte sits in a hold register; the cycle after, the decode
// logic works one nibble per cycle, unless rsp_chan stalls, against the
// history registers and writes the output register, so each sample passes
// through the hold register and then the output register.
// header bytes and bytes of a stopped voice finish without waiting on rsp_chan
// and give no beat; a data byte is decoded one nibble at a time, since the
// second nibble predicts from the first, unless the first ends the voice.
// sustained rate: one sample beat per cycle while rsp_chan takes them.
// a new byte is taken in the cycle the held one finishes, while the output
// register may still hold an untaken sample.
// reset clears the voice state and the valid flags of the hold and output registers.
// when rsp_chan stalls, the output register holds its sample and the decode
// waits; header bytes still pass until a data byte is held.
module adpcm_block_decoder (
   input logic      clock,
   input logic      reset,
   abd_req_if.sink  req_chan,
   abd_rsp_if.source rsp_chan
);

   // hold register
   logic       hold_valid_ff;
   logic [7:0] hold_byte_ff;
   logic       hold_start_ff;
   logic       hold_phase_ff;

   // voice state
   logic [3:0]        pos_ff, pos_in;
   logic [3:0]        shift_ff, shift_in;
   logic [3:0]        filter_ff, filter_in;
   logic [7:0]        flags_ff, flags_in;
   abd_pkg::pcm_type  hist1_ff, hist1_in;
   abd_pkg::pcm_type  hist2_ff, hist2_in;
   logic [15:0]       count_ff, count_in;
   logic              stop_ff, stop_in;

   // output register
   logic              rsp_valid_ff;
   abd_pkg::pcm_type  rsp_sample_ff;
   logic              rsp_pair_ff;
   logic              rsp_loop_ff;
   logic              rsp_end_ff;
   logic              rsp_ovf_ff;

   // effective state after an optional voice clear
   logic              clear_now;
   logic [3:0]        e_pos, e_shift, e_filter;
   logic [7:0]        e_flags;
   abd_pkg::pcm_type  e_hist1, e_hist2;
   logic [15:0]       e_count;
   logic              e_stop;

   logic              slot_free;
   logic              fire;
   logic              emit;
   logic              done;

   // nibble decode
   logic [3:0]                nib;
   logic signed [15:0]        base;
   abd_pkg::coef_type         k0, k1;
   logic signed [23:0]        m0, m1;
   logic signed [24:0]        acc;
   logic signed [19:0]        sum;
   abd_pkg::pcm_type          sat;
   logic [15:0]               count_nx;
   logic                      block_last;
   logic                      ovf;
   logic                      ends;
   logic                      loops;

   assign clear_now = hold_start_ff && !hold_phase_ff;
   assign e_pos     = clear_now ? 4'd0 : pos_ff;
   assign e_shift   = clear_now ? 4'd0 : shift_ff;
   assign e_filter  = clear_now ? 4'd0 : filter_ff;
   assign e_flags   = clear_now ? 8'd0 : flags_ff;
   assign e_hist1   = clear_now ? 16'sd0 : hist1_ff;
   assign e_hist2   = clear_now ? 16'sd0 : hist2_ff;
   assign e_count   = clear_now ? 16'd0 : count_ff;
   assign e_stop    = clear_now ? 1'b0 : stop_ff;

   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   assign nib        = hold_phase_ff ? hold_byte_ff[7:4] : hold_byte_ff[3:0];
   assign base       = $signed({nib, 12'd0}) >>> e_shift;
   assign k0         = abd_pkg::coef_first(e_filter);
   assign k1         = abd_pkg::coef_second(e_filter);
   assign m0         = e_hist1 * k0;
   assign m1         = e_hist2 * k1;
   assign acc        = {m0[23], m0} + {m1[23], m1} + 25'sd32;
   assign sum        = {{4{base[15]}}, base} + {acc[24], acc[24:6]};
   assign count_nx   = (e_count < abd_pkg::MAX_SAMPLES) ? 16'(e_count + 16'd1) : e_count;
   assign ovf        = (count_nx == abd_pkg::MAX_SAMPLES);
   assign block_last = hold_phase_ff && (pos_ff == abd_pkg::POS_WRAP);
   assign ends       = ovf || (block_last && (e_flags == abd_pkg::FLAG_END ||
                                              e_flags == abd_pkg::FLAG_END_LOOP));
   assign loops      = !ovf && block_last && (e_flags == abd_pkg::FLAG_LOOP);

   always_comb begin
      if (sum > 20'sd32767) begin
         sat = 16'sh7fff;
      end else if (sum < -20'sd32768) begin
         sat = 16'sh8000;
      end else begin
         sat = sum[15:0];
      end
   end

   always_comb begin
      fire      = 1'b0;
      emit      = 1'b0;
      done      = 1'b0;
      pos_in    = pos_ff;
      shift_in  = shift_ff;
      filter_in = filter_ff;
      flags_in  = flags_ff;
      hist1_in  = hist1_ff;
      hist2_in  = hist2_ff;
      count_in  = count_ff;
      stop_in   = stop_ff;
      if (hold_valid_ff) begin
         if (!hold_phase_ff && (e_stop || e_pos == abd_pkg::POS_HEADER ||
                                e_pos == abd_pkg::POS_FLAGS)) begin
            fire = 1'b1;
            done = 1'b1;
         end else begin
            fire = slot_free;
            emit = slot_free;
            done = slot_free && (hold_phase_ff || ends);
         end
      end
      if (fire) begin
         pos_in    = e_pos;
         shift_in  = e_shift;
         filter_in = e_filter;
         flags_in  = e_flags;
         hist1_in  = e_hist1;
         hist2_in  = e_hist2;
         count_in  = e_count;
         stop_in   = e_stop;
         if (!e_stop && !hold_phase_ff) begin
            pos_in = 4'(e_pos + 4'd1);
         end
         if (!e_stop && !hold_phase_ff && e_pos == abd_pkg::POS_HEADER) begin
            shift_in  = hold_byte_ff[3:0];
            filter_in = hold_byte_ff[7:4];
         end
         if (!e_stop && !hold_phase_ff && e_pos == abd_pkg::POS_FLAGS) begin
            flags_in = hold_byte_ff;
         end
         if (emit) begin
            hist2_in = e_hist1;
            hist1_in = sat;
            count_in = count_nx;
            stop_in  = ends;
         end
      end
   end

   assign req_chan.ready = !hold_valid_ff || done;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         hold_phase_ff <= 1'b0;
      end else if (req_chan.valid && req_chan.ready) begin
         hold_valid_ff <= 1'b1;
         hold_phase_ff <= 1'b0;
      end else if (done) begin
         hold_valid_ff <= 1'b0;
         hold_phase_ff <= 1'b0;
      end else if (emit) begin
         hold_phase_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         hold_byte_ff  <= req_chan.data_byte;
         hold_start_ff <= req_chan.voice_start;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= 4'd0;
         shift_ff  <= 4'd0;
         filter_ff <= 4'd0;
         flags_ff  <= 8'd0;
         hist1_ff  <= 16'sd0;
         hist2_ff  <= 16'sd0;
         count_ff  <= 16'd0;
         stop_ff   <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         shift_ff  <= shift_in;
         filter_ff <= filter_in;
         flags_ff  <= flags_in;
         hist1_ff  <= hist1_in;
         hist2_ff  <= hist2_in;
         count_ff  <= count_in;
         stop_ff   <= stop_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_sample_ff <= sat;
         rsp_pair_ff   <= hold_phase_ff;
         rsp_loop_ff   <= loops;
         rsp_end_ff    <= ends;
         rsp_ovf_ff    <= ovf;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.sample          = rsp_sample_ff;
   assign rsp_chan.pair_last       = rsp_pair_ff;
   assign rsp_chan.loop_point_next = rsp_loop_ff;
   assign rsp_chan.voice_end       = rsp_end_ff;
   assign rsp_chan.overflow        = rsp_ovf_ff;

endmodule

/* rtl/abd_checker.sv */
// port checker for the adpcm block decoder and its bind
module abd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input abd_pkg::pcm_type rsp_sample,
   input logic             rsp_pair_last,
   input logic             rsp_loop_point_next,
   input logic             rsp_voice_end,
   input logic             rsp_overflow
);

   // stalled beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample))
      else $error("stalled response beat changed");

   // overflow ends the voice and is never a loop point
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |-> rsp_voice_end && !rsp_loop_point_next)
      else $error("overflow beat without end or with loop mark");

   // block marks only on the second sample of a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_loop_point_next || (rsp_voice_end && !rsp_overflow))
      |-> rsp_pair_last)
      else $error("block mark on first sample of a byte");

   // no beat right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind adpcm_block_decoder abd_checker u_abd_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_chan.valid),
   .rsp_ready           (rsp_chan.ready),
   .rsp_sample          (rsp_chan.sample),
   .rsp_pair_last       (rsp_chan.pair_last),
   .rsp_loop_point_next (rsp_chan.loop_point_next),
   .rsp_voice_end       (rsp_chan.voice_end),
   .rsp_overflow        (rsp_chan.overflow)
);
